// File: rtl/plwn_pkg.sv
// Package for the particle log-weight normaliser: widths, constants, the
// controller/datapath command and status structs and the exp2 root table.
// No dependencies.
`default_nettype none

package plwn_pkg;

	localparam int MAX_PARTICLES = 64;
	localparam int IDX_W         = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = 7;
	localparam int SIG_W         = 23;
	localparam int DIST_W        = 24;
	localparam int ACC_W         = 40;
	localparam int LW_W          = 25;
	localparam int LN_X_W        = 40;
	localparam int LN_W          = 24;
	localparam int QUAD_W        = 18;
	localparam int LL_W          = 26;
	localparam int EXP_W         = 33;
	localparam int SUM_W         = IDX_W + EXP_W;
	localparam int CFG_IDX_W     = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RAY_SIGMA      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'd1;

	localparam logic [SIG_W-1:0]  SIGMA_RESET = 23'd6554;
	localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd64;

	// 0.5*ln(2*pi) in Q16.16, ln2 in Q0.32 and log2(e) in Q1.32
	localparam logic [LL_W-1:0]   HALF_LN_2PI_Q16 = 26'd60224;
	localparam logic [31:0]       LN2_Q32         = 32'd2977044472;
	localparam logic [32:0]       LOG2E_Q32       = 33'd6196328019;

	// Quadratic term of a clamped point: 2.0 or 0.125 in Q16.16
	localparam logic [QUAD_W-1:0] QUAD_CLAMP_WIDE    = 18'd131072;
	localparam logic [QUAD_W-1:0] QUAD_CLAMP_SPECIAL = 18'd8192;

	// Weight floor of -200 in Q16.16, at accumulator width plus one
	localparam logic signed [ACC_W:0] FLOOR_Q16 = -41'sd13107200;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic ln_start;
		logic ln_sum;
		logic div_start;
		logic rd_ptr;
		logic mem_rd;
		logic ll_upd;
		logic acc_wr;
		logic max_upd;
		logic ptr_clr;
		logic ptr_inc;
		logic sum_clr;
		logic exp_start;
		logic out_load;
		logic clear_all;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ln_done;
		logic div_done;
		logic exp_done;
		logic ptr_last;
		logic out_taken;
		logic last_item;
	} stat_t;

	typedef logic [15:0][31:0] root_tab_t;

	// Bitwise integer square root, evaluated at elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bitv;
		res  = '0;
		rem  = n;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Entry j-1 holds 2^(-2^-j) in Q0.32, built by repeated floor square roots
	function automatic root_tab_t make_roots();
		root_tab_t   tab;
		logic [63:0] r;
		r      = isqrt64(64'd1 << 63);
		tab[0] = r[31:0];
		for (int j = 1; j < 16; j++) begin
			r      = isqrt64({r[31:0], 32'd0});
			tab[j] = r[31:0];
		end
		return tab;
	endfunction

	localparam root_tab_t EXP2_ROOT = make_roots();

endpackage

`default_nettype wire

// File: rtl/plwn_ln.sv
// Iterative fixed-point natural log unit: normalise, 16 squarings, scale by ln2.
// Result is ln(x * 2^-fb) in Q16.16, fb being 16 or 32. Uses plwn_pkg.
`default_nettype none

module plwn_ln (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic                              fb32,
	input  wire logic [plwn_pkg::LN_X_W-1:0]       x,
	output logic                                   done,
	output logic signed [plwn_pkg::LN_W-1:0]       result
);

	localparam int XW = plwn_pkg::LN_X_W;
	localparam int PW = $clog2(XW);
	localparam logic [31:0] LN2_Q32_EXT = plwn_pkg::LN2_Q32;

	typedef enum logic [4:0] {
		LN_IDLE = 5'b00001,
		LN_NORM = 5'b00010,
		LN_SQ   = 5'b00100,
		LN_ABS  = 5'b01000,
		LN_MUL  = 5'b10000
	} ln_phase_t;

	ln_phase_t         phase_q;
	logic [XW-1:0]     x_q;
	logic [PW-1:0]     p_q;
	logic [30:0]       m_q;
	logic [15:0]       frac_q;
	logic [3:0]        step_q;
	logic              fb32_q;
	logic [21:0]       mag_q;
	logic              neg_q;
	logic              done_q;
	logic signed [23:0] result_q;

	logic [61:0]        sq;
	logic [31:0]        sq_hi;
	logic signed [23:0] l2;
	logic [23:0]        l2_abs;
	logic [54:0]        scaled;
	logic [22:0]        res_mag;

	// Square the mantissa and form the signed log2 before scaling
	always_comb begin
		sq      = {31'd0, m_q} * {31'd0, m_q};
		sq_hi   = sq[61:30];
		l2      = $signed({{(24-PW-16){1'b0}}, p_q, frac_q})
		        - (fb32_q ? 24'sd2097152 : 24'sd1048576);
		l2_abs  = l2[23] ? 24'(-l2) : 24'(l2);
		scaled  = {33'd0, mag_q} * {23'd0, LN2_Q32_EXT} + 55'd2147483648;
		res_mag = scaled[54:32];
	end

	// Advance the log sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= LN_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				LN_IDLE: begin
					if (start) phase_q <= LN_NORM;
				end
				LN_NORM: begin
					if (x_q[XW-1]) phase_q <= LN_SQ;
				end
				LN_SQ: begin
					if (step_q == 4'd15) phase_q <= LN_ABS;
				end
				LN_ABS: begin
					phase_q <= LN_MUL;
				end
				LN_MUL: begin
					done_q  <= 1'b1;
					phase_q <= LN_IDLE;
				end
				default: phase_q <= LN_IDLE;
			endcase
		end
	end

	// Hold the working values
	always_ff @(posedge clk) begin
		case (phase_q)
			LN_IDLE: begin
				if (start) begin
					x_q    <= (x == '0) ? XW'(1) : x;
					p_q    <= PW'(XW - 1);
					fb32_q <= fb32;
				end
			end
			LN_NORM: begin
				if (x_q[XW-1]) begin
					m_q    <= x_q[XW-1 -: 31];
					frac_q <= '0;
					step_q <= '0;
				end else begin
					x_q <= {x_q[XW-2:0], 1'b0};
					p_q <= p_q - PW'(1);
				end
			end
			LN_SQ: begin
				step_q <= step_q + 4'd1;
				if (sq_hi[31]) begin
					m_q    <= sq_hi[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= sq_hi[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			LN_ABS: begin
				mag_q <= l2_abs[21:0];
				neg_q <= l2[23];
			end
			LN_MUL: begin
				result_q <= neg_q ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: rtl/plwn_ctrl.sv
// Controller state machine of the log-weight normaliser: sequences accumulation,
// the max, exp-sum and output passes. Uses plwn_pkg command and status structs.
`default_nettype none

module plwn_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire plwn_pkg::stat_t stat,
	output plwn_pkg::cmd_t       cmd
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_LN_SIG   = 14'b00000000000010,
		S_DIV      = 14'b00000000000100,
		S_ACC_RD   = 14'b00000000001000,
		S_ACC_WR   = 14'b00000000010000,
		S_MAX_RD   = 14'b00000000100000,
		S_MAX_CMP  = 14'b00000001000000,
		S_EXP_RD   = 14'b00000010000000,
		S_EXP_GO   = 14'b00000100000000,
		S_EXP_RUN  = 14'b00001000000000,
		S_LN_SUM   = 14'b00010000000000,
		S_OUT_RD   = 14'b00100000000000,
		S_OUT_LOAD = 14'b01000000000000,
		S_OUT_HOLD = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_ptr = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load     = 1'b1;
					cmd.ln_start = 1'b1;
					state_d      = S_LN_SIG;
				end
			end
			S_LN_SIG: begin
				if (stat.ln_done) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) state_d = S_ACC_RD;
			end
			S_ACC_RD: begin
				cmd.rd_ptr = 1'b0;
				cmd.mem_rd = 1'b1;
				cmd.ll_upd = 1'b1;
				state_d    = S_ACC_WR;
			end
			S_ACC_WR: begin
				cmd.acc_wr = 1'b1;
				if (stat.last_item) begin
					cmd.ptr_clr = 1'b1;
					state_d     = S_MAX_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MAX_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_MAX_CMP;
			end
			S_MAX_CMP: begin
				cmd.max_upd = 1'b1;
				if (stat.ptr_last) begin
					cmd.ptr_clr = 1'b1;
					cmd.sum_clr = 1'b1;
					state_d     = S_EXP_RD;
				end else begin
					cmd.ptr_inc = 1'b1;
					state_d     = S_MAX_RD;
				end
			end
			S_EXP_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_EXP_GO;
			end
			S_EXP_GO: begin
				cmd.exp_start = 1'b1;
				state_d       = S_EXP_RUN;
			end
			S_EXP_RUN: begin
				if (stat.exp_done) begin
					if (stat.ptr_last) begin
						cmd.ln_start = 1'b1;
						cmd.ln_sum   = 1'b1;
						cmd.ptr_clr  = 1'b1;
						state_d      = S_LN_SUM;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = S_EXP_RD;
					end
				end
			end
			S_LN_SUM: begin
				if (stat.ln_done) state_d = S_OUT_RD;
			end
			S_OUT_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_OUT_LOAD;
			end
			S_OUT_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT_HOLD;
			end
			S_OUT_HOLD: begin
				if (stat.out_taken) begin
					if (stat.ptr_last) begin
						cmd.clear_all = 1'b1;
						state_d       = S_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = S_OUT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/plwn_dp.sv
// Datapath of the log-weight normaliser: configuration registers, weight memory,
// quadratic-term divider, exp unit, accumulators and output register.
// Uses plwn_pkg and plwn_ln.
`default_nettype none

module plwn_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [plwn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [plwn_pkg::SIG_W-1:0]          cfg_data,
	input  wire logic [plwn_pkg::IDX_W-1:0]          particle_index,
	input  wire logic signed [plwn_pkg::DIST_W-1:0]  distance,
	input  wire logic                                special_cell,
	input  wire logic                                last_of_set,
	input  wire plwn_pkg::cmd_t                      cmd,
	output plwn_pkg::stat_t                          stat,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [plwn_pkg::IDX_W-1:0]               out_particle,
	output logic signed [plwn_pkg::LW_W-1:0]         log_weight,
	output logic                                     last_result
);

	localparam int NP   = plwn_pkg::MAX_PARTICLES;
	localparam int IW   = plwn_pkg::IDX_W;
	localparam int CW   = plwn_pkg::CNT_W;
	localparam int SW   = plwn_pkg::SIG_W;
	localparam int AW   = plwn_pkg::ACC_W;
	localparam int LLW  = plwn_pkg::LL_W;
	localparam int LNW  = plwn_pkg::LN_W;
	localparam int QW   = plwn_pkg::QUAD_W;
	localparam int XW   = plwn_pkg::LN_X_W;
	localparam int SUMW = plwn_pkg::SUM_W;
	localparam int LWW  = plwn_pkg::LW_W;
	localparam int DIST_WL = plwn_pkg::DIST_W;

	localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_INIT = 4'b0100,
		D_RUN  = 4'b1000
	} div_phase_t;

	typedef enum logic [3:0] {
		E_IDLE  = 4'b0001,
		E_Y     = 4'b0010,
		E_STEP  = 4'b0100,
		E_SHIFT = 4'b1000
	} exp_phase_t;

	// Configuration
	logic [SW-1:0] sigma_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] sig_eff;
	logic [CW-1:0] cnt_m1;
	logic [IW-1:0] last_ptr;

	// Latched input item
	logic [IW-1:0]            idx_q;
	logic signed [DIST_WL-1:0] dist_q;
	logic                     special_q;
	logic                     last_q;

	// Log unit interface
	logic                  ln_done;
	logic signed [LNW-1:0] ln_result;
	logic                  ln_sum_q;
	logic signed [LNW-1:0] lnsig_q;
	logic signed [LNW-1:0] lnsum_q;
	logic [XW-1:0]         ln_x;

	// Divider
	div_phase_t     d_phase_q;
	logic [45:0]    dsq_q;
	logic [45:0]    den_q;
	logic [45:0]    rem_q;
	logic [17:0]    numlo_q;
	logic [QW-1:0]  quo_q;
	logic [4:0]     qcnt_q;
	logic [QW-1:0]  quad_q;
	logic           div_done_q;
	logic [22:0]    dmag;
	logic           inrange;
	logic [61:0]    num;
	logic [46:0]    trial;
	logic           qbit;
	logic [45:0]    rem_next;

	// Weight memory
	logic [AW-1:0]        weight_mem [NP];
	logic [NP-1:0]        vld_q;
	logic [AW-1:0]        rdata_q;
	logic                 rvld_q;
	logic [IW-1:0]        rd_addr;
	logic signed [AW-1:0] rd_val;
	logic                 idx_ok;
	logic                 acc_we;
	logic signed [AW:0]   acc_sum;
	logic signed [AW-1:0] acc_sat;
	logic signed [LLW-1:0] ll_q;

	// Passes
	logic [IW-1:0]        ptr_q;
	logic signed [AW-1:0] max_q;
	logic signed [AW:0]   wdiff;
	logic signed [AW:0]   wcl;
	logic [AW:0]          tneg;
	logic [SUMW-1:0]      sum_q;

	// Exp unit
	exp_phase_t    e_phase_q;
	logic [23:0]   t_q;
	logic [4:0]    k_q;
	logic [15:0]   f_q;
	logic [32:0]   v_q;
	logic [3:0]    estep_q;
	logic          exp_done_q;
	logic [56:0]   yprod;
	logic [24:0]   y;
	logic [65:0]   vprod;
	logic [33:0]   half;
	logic [33:0]   vsh;

	// Output register
	logic                   out_valid_q;
	logic [IW-1:0]          out_particle_q;
	logic signed [LWW-1:0]  log_weight_q;
	logic                   last_result_q;
	logic signed [AW:0]     r_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= plwn_pkg::SIGMA_RESET;
			count_q <= plwn_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				plwn_pkg::REG_RAY_SIGMA:      sigma_q <= cfg_data;
				plwn_pkg::REG_PARTICLE_COUNT: count_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Effective sigma and last particle in use
	always_comb begin
		sig_eff = (sigma_q == '0) ? SW'(1) : sigma_q;
		cnt_m1  = count_q - CW'(1);
		if (count_q == '0) begin
			last_ptr = '0;
		end else if (count_q >= CW'(NP)) begin
			last_ptr = IW'(NP - 1);
		end else begin
			last_ptr = cnt_m1[IW-1:0];
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q     <= particle_index;
			dist_q    <= distance;
			special_q <= special_cell;
			last_q    <= last_of_set;
		end
	end

	// Shared log unit
	assign ln_x = cmd.ln_sum ? XW'(sum_q) : XW'(sig_eff);

	plwn_ln u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ln_start),
		.fb32   (cmd.ln_sum),
		.x      (ln_x),
		.done   (ln_done),
		.result (ln_result)
	);

	always_ff @(posedge clk) begin
		if (cmd.ln_start) ln_sum_q <= cmd.ln_sum;
		if (ln_done) begin
			if (ln_sum_q) lnsum_q <= ln_result;
			else lnsig_q <= ln_result;
		end
	end

	// Clamp test and division step
	always_comb begin
		dmag = dist_q[22:0];
		if (special_q) begin
			inrange = !dist_q[DIST_WL-1] && ({dmag, 1'b0} <= {1'b0, sig_eff});
		end else begin
			inrange = !dist_q[DIST_WL-1] && ({1'b0, dmag} <= {sig_eff, 1'b0});
		end
		num      = {1'b0, dsq_q, 15'd0} + {17'd0, den_q[45:1]};
		trial    = {rem_q, numlo_q[17]};
		qbit     = (trial >= {1'b0, den_q});
		rem_next = qbit ? 46'(trial - {1'b0, den_q}) : trial[45:0];
	end

	// Divider sequence: quad = round(d*d*32768 / sigma^2) in range, else the clamp value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_phase_q  <= D_IDLE;
			div_done_q <= 1'b0;
		end else begin
			div_done_q <= 1'b0;
			case (d_phase_q)
				D_IDLE: begin
					if (cmd.div_start) begin
						if (inrange) d_phase_q <= D_MUL;
						else div_done_q <= 1'b1;
					end
				end
				D_MUL:  d_phase_q <= D_INIT;
				D_INIT: d_phase_q <= D_RUN;
				D_RUN: begin
					if (qcnt_q == 5'(QW - 1)) begin
						div_done_q <= 1'b1;
						d_phase_q  <= D_IDLE;
					end
				end
				default: d_phase_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (d_phase_q)
			D_IDLE: begin
				if (cmd.div_start && !inrange) begin
					quad_q <= special_q ? plwn_pkg::QUAD_CLAMP_SPECIAL
					                    : plwn_pkg::QUAD_CLAMP_WIDE;
				end
			end
			D_MUL: begin
				dsq_q <= dmag * dmag;
				den_q <= sig_eff * sig_eff;
			end
			D_INIT: begin
				rem_q   <= {2'd0, num[61:18]};
				numlo_q <= num[17:0];
				quo_q   <= '0;
				qcnt_q  <= '0;
			end
			D_RUN: begin
				rem_q   <= rem_next;
				numlo_q <= {numlo_q[16:0], 1'b0};
				quo_q   <= {quo_q[QW-2:0], qbit};
				qcnt_q  <= qcnt_q + 5'd1;
				if (qcnt_q == 5'(QW - 1)) quad_q <= {quo_q[QW-2:0], qbit};
			end
			default: ;
		endcase
	end

	// Memory read, accumulate with saturation
	always_comb begin
		rd_addr = cmd.rd_ptr ? ptr_q : idx_q;
		rd_val  = rvld_q ? $signed(rdata_q) : '0;
		idx_ok  = ({1'b0, idx_q} < (IW + 1)'(NP));
		acc_we  = cmd.acc_wr && idx_ok;
		acc_sum = $signed({rd_val[AW-1], rd_val})
		        + $signed({{(AW + 1 - LLW){ll_q[LLW-1]}}, ll_q});
		if (acc_sum[AW] != acc_sum[AW-1]) begin
			acc_sat = acc_sum[AW] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_sum[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rdata_q <= weight_mem[rd_addr];
			rvld_q  <= vld_q[rd_addr];
		end
		if (acc_we) weight_mem[idx_q] <= acc_sat;
	end

	// Valid bits stand for the zeroed store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clear_all) begin
			vld_q <= '0;
		end else if (acc_we) begin
			vld_q[idx_q] <= 1'b1;
		end
	end

	// Per-point log-likelihood term
	always_ff @(posedge clk) begin
		if (cmd.ll_upd) begin
			ll_q <= $signed(LLW'(0) - plwn_pkg::HALF_LN_2PI_Q16
			      - {{(LLW - LNW){lnsig_q[LNW-1]}}, lnsig_q}
			      - {{(LLW - QW){1'b0}}, quad_q});
		end
	end

	// Particle pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.ptr_clr) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + IW'(1);
		end
	end

	// Clamped weight relative to the maximum
	always_comb begin
		wdiff  = $signed({rd_val[AW-1], rd_val}) - $signed({max_q[AW-1], max_q});
		wcl    = (wdiff < plwn_pkg::FLOOR_Q16) ? plwn_pkg::FLOOR_Q16 : wdiff;
		tneg   = (AW + 1)'(-wcl);
		r_full = wcl - $signed({{(AW + 1 - LNW){lnsum_q[LNW-1]}}, lnsum_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.max_upd && ((ptr_q == '0) || (rd_val > max_q))) max_q <= rd_val;
	end

	// Exp arithmetic
	always_comb begin
		yprod = {33'd0, t_q} * {24'd0, plwn_pkg::LOG2E_Q32} + 57'd2147483648;
		y     = yprod[56:32];
		vprod = {33'd0, v_q} * {34'd0, plwn_pkg::EXP2_ROOT[estep_q]} + 66'd2147483648;
		half  = 34'd1 << (k_q - 5'd1);
		vsh   = ({1'b0, v_q} + half) >> k_q;
	end

	// Exp sequence and sum of exponentials
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_phase_q  <= E_IDLE;
			exp_done_q <= 1'b0;
		end else begin
			exp_done_q <= 1'b0;
			case (e_phase_q)
				E_IDLE: begin
					if (cmd.exp_start) e_phase_q <= E_Y;
				end
				E_Y: begin
					if (y[24:16] >= 9'd32) begin
						exp_done_q <= 1'b1;
						e_phase_q  <= E_IDLE;
					end else begin
						e_phase_q <= E_STEP;
					end
				end
				E_STEP: begin
					if (estep_q == 4'd15) e_phase_q <= E_SHIFT;
				end
				E_SHIFT: begin
					exp_done_q <= 1'b1;
					e_phase_q  <= E_IDLE;
				end
				default: e_phase_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) sum_q <= '0;
		case (e_phase_q)
			E_IDLE: begin
				if (cmd.exp_start) t_q <= tneg[23:0];
			end
			E_Y: begin
				k_q     <= y[20:16];
				f_q     <= y[15:0];
				v_q     <= 33'h1_0000_0000;
				estep_q <= '0;
			end
			E_STEP: begin
				if (f_q[15]) v_q <= vprod[64:32];
				f_q     <= {f_q[14:0], 1'b0};
				estep_q <= estep_q + 4'd1;
			end
			E_SHIFT: begin
				if (k_q == '0) sum_q <= sum_q + SUMW'(v_q);
				else sum_q <= sum_q + SUMW'(vsh[32:0]);
			end
			default: ;
		endcase
	end

	// Output register: load one result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_particle_q <= ptr_q;
			log_weight_q   <= r_full[LWW-1:0];
			last_result_q  <= (ptr_q == last_ptr);
		end
	end

	always_comb begin
		stat.ln_done   = ln_done;
		stat.div_done  = div_done_q;
		stat.exp_done  = exp_done_q;
		stat.ptr_last  = (ptr_q == last_ptr);
		stat.out_taken = out_valid_q && !out_stall;
		stat.last_item = last_q;
	end

	assign out_valid    = out_valid_q;
	assign out_particle = out_particle_q;
	assign log_weight   = log_weight_q;
	assign last_result  = last_result_q;

`ifndef SYNTH
	a_quad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_q |-> (quad_q <= plwn_pkg::QUAD_CLAMP_WIDE))
		else $error("quadratic term above the wide clamp");

	a_exp_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(e_phase_q == E_STEP) |-> (v_q <= 33'h1_0000_0000))
		else $error("exp value above one");

	a_out_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (log_weight_q[LWW-1] || (log_weight_q == '0)))
		else $error("normalised log weight above zero");
`endif

endmodule

`default_nettype wire

// File: rtl/particle_log_weight_normalizer_core.sv
// Per point: accept, ln(sigma) (normalising shift one bit at a time, then 16 squarings),
// the divider (skipped when the distance is clamped), then accumulate. On the last point:
// the max pass over the particles, the exp unit per particle (cut short when the
// exponential underflows), the log of the sum, then one result at a time to the output,
// each held through any output stall. One point at a time: the next item is taken only
// when all this is done. Reset: registers to reset values, store reads as zero.
`default_nettype none

module particle_log_weight_normalizer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [plwn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [plwn_pkg::SIG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [plwn_pkg::IDX_W-1:0]          particle_index,
	input  wire logic signed [plwn_pkg::DIST_W-1:0]  distance,
	input  wire logic                                special_cell,
	input  wire logic                                last_of_set,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [plwn_pkg::IDX_W-1:0]               out_particle,
	output logic signed [plwn_pkg::LW_W-1:0]         log_weight,
	output logic                                     last_result
);

	plwn_pkg::cmd_t  cmd;
	plwn_pkg::stat_t stat;

	// Sequencer
	plwn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, storage and output register
	plwn_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.particle_index (particle_index),
		.distance       (distance),
		.special_cell   (special_cell),
		.last_of_set    (last_of_set),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_particle   (out_particle),
		.log_weight     (log_weight),
		.last_result    (last_result)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for particle_log_weight_normalizer_core: streams scored
// points in sets, predicts the normalised log weights in fixed point and checks them.
// Depends on plwn_pkg and the core RTL only.
`timescale 1ns / 100ps
`default_nettype none

module tb;

	localparam int LIMIT_CYCLES = 5000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int MAX_SHOWN = 10;
	localparam longint unsigned LN2_K = 64'd2977044472;
	localparam longint unsigned LOG2E_K = 64'd6196328019;
	localparam longint HALF_LN_2PI = 60224;
	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;
	localparam longint WEIGHT_FLOOR = -64'sd13107200;

	typedef struct {
		logic [plwn_pkg::IDX_W-1:0] idx;
		logic [plwn_pkg::LW_W-1:0] lw;
		logic last;
	} weight_item_t;

	typedef struct {
		logic [plwn_pkg::IDX_W-1:0] idx;
		int dval;
		bit special;
		bit last;
		bit typed;
	} point_row_t;

	typedef struct {
		int sigma;
		int count;
		bit idling;
	} setting_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [plwn_pkg::CFG_IDX_W-1:0] cfg_index = plwn_pkg::REG_RAY_SIGMA;
	logic [plwn_pkg::SIG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [plwn_pkg::IDX_W-1:0] particle_index = '0;
	logic signed [plwn_pkg::DIST_W-1:0] distance = '0;
	logic special_cell = 0;
	logic last_of_set = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [plwn_pkg::IDX_W-1:0] out_particle;
	logic signed [plwn_pkg::LW_W-1:0] log_weight;
	logic last_result;

	// Predictor state
	longint unsigned root_q32[1:16];
	longint weight_acc[plwn_pkg::MAX_PARTICLES];
	longint unsigned sigma_reg = 6554;
	int count_reg = 64;
	logic [plwn_pkg::LW_W-1:0] norm_lw[plwn_pkg::MAX_PARTICLES];

	weight_item_t weights_due[$];
	int cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int points_sent = 0;
	int sets_sent = 0;
	bit idling = 1;
	int stall_left = 0;

	point_row_t directed[10];
	setting_t settings[8];

	particle_log_weight_normalizer_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.particle_index(particle_index), .distance(distance),
		.special_cell(special_cell), .last_of_set(last_of_set),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_particle(out_particle), .log_weight(log_weight),
		.last_result(last_result)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// ln(x * 2^-fb) in Q16.16
	function automatic longint ln_q16(longint unsigned x, int fb);
		int p;
		longint unsigned m;
		longint unsigned frac;
		longint unsigned mag;
		longint l2;
		if (x == 0) x = 1;
		p = 63;
		frac = 0;
		while (x[p] == 1'b0) p--;
		m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		l2 = longint'((longint'(p) << 16) | frac) - (longint'(fb) << 16);
		mag = (l2 < 0) ? -l2 : l2;
		mag = (mag * LN2_K + (64'd1 << 31)) >> 32;
		return (l2 < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// exp(w) for Q16.16 w <= 0, result Q0.32
	function automatic longint unsigned exp_q32(longint w);
		longint unsigned y;
		longint unsigned v;
		longint unsigned k;
		longint unsigned f;
		v = 64'd1 << 32;
		y = (longint'(-w) * LOG2E_K + (64'd1 << 31)) >> 32;
		k = y >> 16;
		f = y & 64'hFFFF;
		if (k >= 32) return 0;
		for (int j = 1; j <= 16; j++)
			if (f[16-j]) v = (v * root_q32[j] + (64'd1 << 31)) >> 32;
		if (k > 0) v = (v + (64'd1 << (k - 1))) >> k;
		return v;
	endfunction

	// Score one point; on the last of a set fill norm_lw and return the result count
	function automatic int score_point(logic [plwn_pkg::IDX_W-1:0] idx,
			logic signed [plwn_pkg::DIST_W-1:0] dval, bit special, bit last);
		longint unsigned sig;
		longint unsigned quad;
		longint d;
		longint ll;
		longint acc;
		longint maxw;
		longint lnsum;
		longint unsigned total;
		bit in_reach;
		int n;
		sig = (sigma_reg == 0) ? 1 : sigma_reg;
		d = dval;
		total = 0;
		if (special) in_reach = d >= 0 && longint'(d) * 2 <= sig;
		else in_reach = d >= 0 && d <= sig * 2;
		if (in_reach) quad = (d * d * 32768 + (sig * sig) / 2) / (sig * sig);
		else quad = special ? 8192 : 131072;
		ll = -HALF_LN_2PI - ln_q16(sig, 16) - longint'(quad);
		acc = weight_acc[idx] + ll;
		if (acc > ACC_HI) acc = ACC_HI;
		if (acc < ACC_LO) acc = ACC_LO;
		weight_acc[idx] = acc;
		if (!last) return 0;
		n = (count_reg < 1) ? 1 : (count_reg > plwn_pkg::MAX_PARTICLES ?
			plwn_pkg::MAX_PARTICLES : count_reg);
		maxw = weight_acc[0];
		for (int i = 1; i < n; i++)
			if (weight_acc[i] > maxw) maxw = weight_acc[i];
		for (int i = 0; i < n; i++) begin
			weight_acc[i] = weight_acc[i] - maxw;
			if (weight_acc[i] < WEIGHT_FLOOR) weight_acc[i] = WEIGHT_FLOOR;
			total += exp_q32(weight_acc[i]);
		end
		lnsum = ln_q16(total, 32);
		for (int i = 0; i < n; i++) norm_lw[i] = plwn_pkg::LW_W'(weight_acc[i] - lnsum);
		for (int i = 0; i < plwn_pkg::MAX_PARTICLES; i++) weight_acc[i] = 0;
		return n;
	endfunction

	// Write one register, then leave the write enable low before returning
	task automatic cfg_write(logic [plwn_pkg::CFG_IDX_W-1:0] index,
			logic [plwn_pkg::SIG_W-1:0] data);
		cfg_we <= 1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 0;
		if (index == plwn_pkg::REG_RAY_SIGMA) sigma_reg = data;
		else count_reg = data[plwn_pkg::CNT_W-1:0];
		@(posedge clk);
	endtask

	// Hold the item until it is taken, then queue what it produces
	task automatic send_point(logic [plwn_pkg::IDX_W-1:0] idx, int dval, bit special,
			bit last, bit typed);
		int gap;
		int n;
		weight_item_t item;
		gap = idling ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		particle_index <= idx;
		distance <= dval[plwn_pkg::DIST_W-1:0];
		special_cell <= special;
		last_of_set <= last;
		do @(posedge clk); while (in_stall);
		points_sent++;
		n = score_point(idx, dval[plwn_pkg::DIST_W-1:0], special, last);
		if (last) sets_sent++;
		if (typed && last) begin
			item.idx = '0;
			item.lw = '0;
			item.last = 1;
			weights_due.push_back(item);
		end else begin
			for (int i = 0; i < n; i++) begin
				item.idx = i;
				item.lw = norm_lw[i];
				item.last = (i == n - 1);
				weights_due.push_back(item);
			end
		end
	endtask

	// Let the block drain before touching its registers
	task automatic wait_idle();
		in_valid <= 0;
		while (weights_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receive side: check each taken item, draw a stall per item
	always @(posedge clk) begin
		weight_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (weights_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected weight: particle %0d lw %0d",
						out_particle, log_weight);
			end else begin
				want = weights_due.pop_front();
				if (want.idx !== out_particle || want.lw !== log_weight
						|| want.last !== last_result) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: expected p%0d lw %0d last %0b, got p%0d lw %0d last %0b",
							want.idx, $signed(want.lw), want.last,
							out_particle, log_weight, last_result);
				end
			end
			stall_left = idling ? $urandom_range(0, 10) : 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1;
			stall_left--;
		end else begin
			out_stall <= 0;
		end
	end

	// Guard against a hung block
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int eff;
		int budget;
		int set_len;
		int lim;
		int dval;
		bit skew;
		logic [plwn_pkg::IDX_W-1:0] idx;
		root_q32[1] = int_sqrt(64'd1 << 63);
		for (int j = 2; j <= 16; j++) root_q32[j] = int_sqrt(root_q32[j-1] << 32);
		for (int i = 0; i < plwn_pkg::MAX_PARTICLES; i++) weight_acc[i] = 0;

		// idx, distance, special, last, typed
		directed[0] = '{6'd0, 0, 0, 1, 1};
		directed[1] = '{6'd63, 8388607, 0, 0, 0};
		directed[2] = '{6'd0, -8388608, 0, 0, 0};
		directed[3] = '{6'd1, 13108, 0, 0, 0};
		directed[4] = '{6'd1, 13109, 0, 0, 0};
		directed[5] = '{6'd2, 3277, 1, 0, 0};
		directed[6] = '{6'd2, 3278, 1, 0, 0};
		directed[7] = '{6'd3, -1, 1, 0, 0};
		directed[8] = '{6'd0, 6554, 0, 1, 1};
		directed[9] = '{6'd42, 0, 1, 1, 1};

		settings[0] = '{6554, 64, 1};
		settings[1] = '{1, 2, 1};
		settings[2] = '{8388607, 2, 0};
		settings[3] = '{0, 5, 1};
		settings[4] = '{300000, 0, 1};
		settings[5] = '{20000, 127, 0};
		settings[6] = '{1000, 16, 1};
		settings[7] = '{6554, 64, 1};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(posedge clk);

		// Single particle: every set normalises to zero
		cfg_write(plwn_pkg::REG_PARTICLE_COUNT, 1);
		foreach (directed[r])
			send_point(directed[r].idx, directed[r].dval, directed[r].special,
				directed[r].last, directed[r].typed);

		// Random sets under each setting
		foreach (settings[s]) begin
			wait_idle();
			idling = settings[s].idling;
			cfg_write(plwn_pkg::REG_RAY_SIGMA, settings[s].sigma);
			cfg_write(plwn_pkg::REG_PARTICLE_COUNT, settings[s].count);
			eff = (count_reg < 1) ? 1 : (count_reg > plwn_pkg::MAX_PARTICLES ?
				plwn_pkg::MAX_PARTICLES : count_reg);
			budget = 41;
			while (budget > 0) begin
				set_len = $urandom_range(1, 16);
				skew = ($urandom_range(0, 3) == 0);
				for (int k = 0; k < set_len; k++) begin
					if (skew) idx = 0;
					else if ($urandom_range(0, 7) == 0) idx = $urandom_range(0, 63);
					else idx = $urandom_range(0, eff - 1);
					lim = (sigma_reg * 3 > 8388607) ? 8388607 : sigma_reg * 3;
					case ($urandom_range(0, 5))
						0: dval = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
						1: dval = -$urandom_range(1, 8388608);
						default: dval = $urandom_range(0, lim);
					endcase
					send_point(idx, dval, $urandom_range(0, 1), k == set_len - 1, 0);
				end
				budget -= set_len;
			end
		end

		wait_idle();
		$display("Sent %0d points in %0d sets over %0d register settings; checked %0d weights.",
			points_sent, sets_sent, $size(settings) + 1, results_seen);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire
